### rtl/rau_pkg.sv
// Shared types, codes and constants of the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

    localparam int DVD_W = 64;               // divider dividend / quotient width
    localparam int DVS_W = 32;               // divider divisor width
    localparam int CNT_W = $clog2(DVD_W);    // divider iteration counter

    localparam logic signed [31:0] EQ_SCALE = 32'sd1000;

    typedef logic [3:0] op_t;
    localparam op_t OP_ADD = 4'd0;
    localparam op_t OP_SUB = 4'd1;
    localparam op_t OP_MUL = 4'd2;
    localparam op_t OP_DIV = 4'd3;
    localparam op_t OP_EQ  = 4'd4;
    localparam op_t OP_GT  = 4'd5;
    localparam op_t OP_LT  = 4'd6;
    localparam op_t OP_INC = 4'd7;
    localparam op_t OP_DEC = 4'd8;

    typedef logic [1:0] st_t;
    localparam st_t ST_OK   = 2'd0;
    localparam st_t ST_OVF  = 2'd1;
    localparam st_t ST_DIV0 = 2'd2;
    localparam st_t ST_ZDEN = 2'd3;

    // multiplier operand pairs
    typedef logic [2:0] msel_t;
    localparam msel_t MS_AN_BD = 3'd0;
    localparam msel_t MS_BN_AD = 3'd1;
    localparam msel_t MS_AD_BD = 3'd2;
    localparam msel_t MS_AN_BN = 3'd3;
    localparam msel_t MS_AD_BN = 3'd4;
    localparam msel_t MS_AN_SC = 3'd5;
    localparam msel_t MS_BN_SC = 3'd6;

    // product destinations
    typedef logic [1:0] mdst_t;
    localparam mdst_t MD_P = 2'd0;
    localparam mdst_t MD_Q = 2'd1;
    localparam mdst_t MD_R = 2'd2;

    // working fraction source / store target
    typedef logic [1:0] wsel_t;
    localparam wsel_t WS_A = 2'd0;
    localparam wsel_t WS_B = 2'd1;
    localparam wsel_t WS_R = 2'd2;

    // divider jobs
    typedef logic [1:0] ddst_t;
    localparam ddst_t DD_MN = 2'd0;
    localparam ddst_t DD_MD = 2'd1;
    localparam ddst_t DD_QA = 2'd2;
    localparam ddst_t DD_QB = 2'd3;

    // comparison outcome source
    typedef logic [1:0] csel_t;
    localparam csel_t CS_NONE = 2'd0;
    localparam csel_t CS_ORD  = 2'd1;
    localparam csel_t CS_EQ   = 2'd2;

    typedef struct packed {
        logic  load_in;
        logic  w_load;
        wsel_t w_sel;
        logic  w_one;
        logic  w_fix;
        logic  w_store;
        logic  gcd_init;
        logic  gcd_step;
        logic  div_go;
        ddst_t div_dst;
        logic  mul_go;
        msel_t mul_sel;
        mdst_t mul_dst;
        logic  form;
        logic  out_go;
        logic  out_w;
        st_t   out_st;
        csel_t cmp_sel;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic zden;
        logic bn_zero;
        logic w_zero;
        logic gcd_eq;
        logic div_done;
        logic a_fits;
        logic b_fits;
        logic pqr_ok;
        logic res_fits;
        logic out_fits;
    } stat_t;

endpackage

### rtl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: controller plus datapath.
`timescale 1ns / 1ps

//  channel   handshake         payload
//  command   start / busy      op, a_num, a_den, b_num, b_den
//  result    done (strobe)     res_num, res_den, cmp_true, status
//
//  A command transfer happens at a rising edge with start high and busy low.
//  One command is worked on at a time; busy stays high until its result is issued.
//  Results hold for one cycle under done; the receiver cannot stall them.
//  Unused codes and input errors are answered straight from decode; gt/lt and eq
//  take longer, and arithmetic is set by the one-step-a-cycle binary gcd and the
//  shared one-bit-a-cycle 64-bit divider (two divisions per nonzero fraction, up
//  to three fractions).
//  Reset (rst_n, async, active low) returns the controller to idle; no clearing pass.

module rational_arithmetic_unit_top
    import rau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         op,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               done,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic               cmp_true,
    output logic [1:0]         status
);

    cmd_t  cmd;    // controller -> datapath
    stat_t stat;   // datapath -> controller

    rau_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    rau_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .op       (op),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .done     (done),
        .res_num  (res_num),
        .res_den  (res_den),
        .cmp_true (cmp_true),
        .status   (status)
    );

`ifndef NO_ASSERTIONS
    // a result is only issued for a command that was in flight
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a command in flight");

    // accepted command keeps the unit busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    // error results are always 0/1 with no comparison outcome
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (res_num == 32'sd0 && res_den == 31'd1 && !cmp_true))
        else $error("error result not cleared to 0/1");

    // denominator of a result is never zero
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res_den != 31'd0))
        else $error("zero result denominator");
`endif

endmodule

### rtl/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rau_div
    import rau_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/rau_dp.sv
// Datapath: operand registers, multiplier, binary gcd, divider and result registers.
`timescale 1ns / 1ps

module rau_dp
    import rau_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [3:0]         op,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               done,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic               cmp_true,
    output logic [1:0]         status
);

    op_t                op_reg, op_next;
    logic signed [32:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [32:0] bn_reg, bn_next, bd_reg, bd_next;
    logic signed [32:0] wn_reg, wn_next, wd_reg, wd_next;
    logic signed [63:0] p_reg, p_next, q_reg, q_next, r_reg, r_next;
    logic [31:0]        gx_reg, gx_next, gy_reg, gy_next;
    logic [4:0]         gk_reg, gk_next;
    logic [31:0]        mn_reg, mn_next, md_reg, md_next;
    logic [63:0]        qa_reg, qa_next, qb_reg, qb_next;
    ddst_t              dd_reg, dd_next;
    logic               done_reg, done_next;
    logic signed [31:0] rn_reg, rn_next;
    logic [30:0]        rd_reg, rd_next;
    logic               cmp_reg, cmp_next;
    st_t                st_reg, st_next;

    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic [31:0]        g, wn_mag, wd_mag, ad_mag, bd_mag;
    logic [63:0]        p_mag;
    logic [63:0]        dvd;
    logic [31:0]        dvs;
    logic               div_done;
    logic [63:0]        div_q;
    logic               ord_out, eq_out, flip;
    logic               uses_b;

    function automatic logic fit33(input logic signed [32:0] x);
        return x[32] == x[31];
    endfunction

    function automatic logic fit64(input logic signed [63:0] x);
        return (&x[63:31]) | ~(|x[63:31]);
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] x);
        logic signed [32:0] t;
        t = x[32] ? -x : x;
        return t[31:0];
    endfunction

    assign uses_b = op_reg <= OP_LT;
    assign g      = gx_reg << gk_reg;
    assign wn_mag = mag33(wn_reg);
    assign wd_mag = mag33(wd_reg);
    assign ad_mag = mag33(ad_reg);
    assign bd_mag = mag33(bd_reg);
    assign p_mag  = p_reg[63] ? 64'(-p_reg) : 64'(p_reg);

    // multiplier operand select
    always_comb
    begin
        ma = an_reg[31:0];
        mb = bd_reg[31:0];
        unique case (cmd.mul_sel)
            MS_AN_BD: begin ma = an_reg[31:0]; mb = bd_reg[31:0]; end
            MS_BN_AD: begin ma = bn_reg[31:0]; mb = ad_reg[31:0]; end
            MS_AD_BD: begin ma = ad_reg[31:0]; mb = bd_reg[31:0]; end
            MS_AN_BN: begin ma = an_reg[31:0]; mb = bn_reg[31:0]; end
            MS_AD_BN: begin ma = ad_reg[31:0]; mb = bn_reg[31:0]; end
            MS_AN_SC: begin ma = an_reg[31:0]; mb = EQ_SCALE; end
            MS_BN_SC: begin ma = bn_reg[31:0]; mb = EQ_SCALE; end
            default:  begin ma = an_reg[31:0]; mb = bd_reg[31:0]; end
        endcase
    end

    assign prod = ma * mb;

    // divider job select
    always_comb
    begin
        unique case (cmd.div_dst)
            DD_MN: begin dvd = {32'd0, wn_mag}; dvs = g;      end
            DD_MD: begin dvd = {32'd0, wd_mag}; dvs = g;      end
            DD_QA: begin dvd = p_mag;           dvs = ad_mag; end
            DD_QB: begin dvd = p_mag;           dvs = bd_mag; end
            default: begin dvd = p_mag;         dvs = ad_mag; end
        endcase
    end

    rau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.div_go),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // comparison outcomes
    assign flip    = ad_reg[32] ^ bd_reg[32];
    assign ord_out = (op_reg == OP_GT) ? (flip ? (p_reg < q_reg) : (p_reg > q_reg))
                                       : (flip ? (p_reg > q_reg) : (p_reg < q_reg));
    assign eq_out  = (qa_reg == qb_reg) &&
                     ((qa_reg == 64'd0) || ((an_reg[32] ^ ad_reg[32]) == (bn_reg[32] ^ bd_reg[32])));

    always_comb
    begin
        op_next   = op_reg;
        an_next   = an_reg;
        ad_next   = ad_reg;
        bn_next   = bn_reg;
        bd_next   = bd_reg;
        wn_next   = wn_reg;
        wd_next   = wd_reg;
        p_next    = p_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        gx_next   = gx_reg;
        gy_next   = gy_reg;
        gk_next   = gk_reg;
        mn_next   = mn_reg;
        md_next   = md_reg;
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        dd_next   = dd_reg;
        rn_next   = rn_reg;
        rd_next   = rd_reg;
        cmp_next  = cmp_reg;
        st_next   = st_reg;
        done_next = cmd.out_go;

        if (cmd.load_in)
        begin
            op_next = op;
            an_next = 33'(a_num);
            ad_next = 33'(a_den);
            bn_next = 33'(b_num);
            bd_next = 33'(b_den);
        end

        if (cmd.w_store)
        begin
            if (cmd.w_sel == WS_B)
            begin
                bn_next = wn_reg;
                bd_next = wd_reg;
            end
            else
            begin
                an_next = wn_reg;
                ad_next = wd_reg;
            end
        end

        if (cmd.w_load)
        begin
            unique case (cmd.w_sel)
                WS_A:    begin wn_next = an_reg;       wd_next = ad_reg;       end
                WS_B:    begin wn_next = bn_reg;       wd_next = bd_reg;       end
                WS_R:    begin wn_next = p_reg[32:0];  wd_next = r_reg[32:0];  end
                default: begin wn_next = an_reg;       wd_next = ad_reg;       end
            endcase
        end

        if (cmd.w_one)
            wd_next = 33'sd1;

        if (cmd.w_fix)
        begin
            wn_next = (wn_reg[32] ^ wd_reg[32]) ? -$signed({1'b0, mn_reg})
                                                : $signed({1'b0, mn_reg});
            wd_next = $signed({1'b0, md_reg});
        end

        // binary gcd, one step a cycle
        if (cmd.gcd_init)
        begin
            gx_next = wn_mag;
            gy_next = wd_mag;
            gk_next = '0;
        end
        else if (cmd.gcd_step)
        begin
            priority if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_next = gx_reg >> 1;
                gy_next = gy_reg >> 1;
                gk_next = gk_reg + 1'b1;
            end
            else if (!gx_reg[0])
                gx_next = gx_reg >> 1;
            else if (!gy_reg[0])
                gy_next = gy_reg >> 1;
            else if (gx_reg > gy_reg)
                gx_next = (gx_reg - gy_reg) >> 1;
            else
                gy_next = (gy_reg - gx_reg) >> 1;
        end

        if (cmd.div_go)
            dd_next = cmd.div_dst;

        if (div_done)
        begin
            unique case (dd_reg)
                DD_MN:   mn_next = div_q[31:0];
                DD_MD:   md_next = div_q[31:0];
                DD_QA:   qa_next = div_q;
                DD_QB:   qb_next = div_q;
                default: qa_next = div_q;
            endcase
        end

        if (cmd.mul_go)
        begin
            unique case (cmd.mul_dst)
                MD_P:    p_next = prod;
                MD_Q:    q_next = prod;
                MD_R:    r_next = prod;
                default: p_next = prod;
            endcase
        end

        if (cmd.form)
        begin
            case (op_reg)
                OP_ADD: p_next = p_reg + q_reg;
                OP_SUB: p_next = p_reg - q_reg;
                OP_INC:
                begin
                    p_next = 64'(an_reg) + 64'(ad_reg);
                    r_next = 64'(ad_reg);
                end
                OP_DEC:
                begin
                    p_next = 64'(an_reg) - 64'(ad_reg);
                    r_next = 64'(ad_reg);
                end
                default: p_next = p_reg;
            endcase
        end

        if (cmd.out_go)
        begin
            rn_next = cmd.out_w ? wn_reg[31:0] : 32'sd0;
            rd_next = cmd.out_w ? wd_reg[30:0] : 31'd1;
            st_next = cmd.out_st;
            unique case (cmd.cmp_sel)
                CS_ORD:  cmp_next = ord_out;
                CS_EQ:   cmp_next = eq_out;
                default: cmp_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        an_reg  <= an_next;
        ad_reg  <= ad_next;
        bn_reg  <= bn_next;
        bd_reg  <= bd_next;
        wn_reg  <= wn_next;
        wd_reg  <= wd_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
        gk_reg  <= gk_next;
        mn_reg  <= mn_next;
        md_reg  <= md_next;
        qa_reg  <= qa_next;
        qb_reg  <= qb_next;
        dd_reg  <= dd_next;
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
        cmp_reg <= cmp_next;
        st_reg  <= st_next;
    end

    always_comb
    begin
        stat.op       = op_reg;
        stat.zden     = (ad_reg == 33'sd0) || (uses_b && (bd_reg == 33'sd0));
        stat.bn_zero  = bn_reg == 33'sd0;
        stat.w_zero   = wn_reg == 33'sd0;
        stat.gcd_eq   = gx_reg == gy_reg;
        stat.div_done = div_done;
        stat.a_fits   = fit33(an_reg) && fit33(ad_reg);
        stat.b_fits   = fit33(bn_reg) && fit33(bd_reg);
        stat.pqr_ok   = fit64(p_reg) && fit64(q_reg) && fit64(r_reg);
        stat.res_fits = fit64(p_reg) && fit64(r_reg);
        stat.out_fits = fit33(wn_reg) && (wd_reg[32:31] == 2'b00);
    end

    assign done     = done_reg;
    assign res_num  = rn_reg;
    assign res_den  = rd_reg;
    assign cmp_true = cmp_reg;
    assign status   = st_reg;

endmodule

### rtl/rau_ctrl.sv
// Controller: sequences normalization, products, division and result transfer.
`timescale 1ns / 1ps

module rau_ctrl
    import rau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_NZ    = 5'd2;
    localparam logic [4:0] S_GCD   = 5'd3;
    localparam logic [4:0] S_DWN   = 5'd4;
    localparam logic [4:0] S_DWD   = 5'd5;
    localparam logic [4:0] S_FIX   = 5'd6;
    localparam logic [4:0] S_NST   = 5'd7;
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_M1    = 5'd9;
    localparam logic [4:0] S_M2    = 5'd10;
    localparam logic [4:0] S_M3    = 5'd11;
    localparam logic [4:0] S_FORM  = 5'd12;
    localparam logic [4:0] S_RCHK  = 5'd13;
    localparam logic [4:0] S_ROUT  = 5'd14;
    localparam logic [4:0] S_CMP_P = 5'd15;
    localparam logic [4:0] S_CMP_Q = 5'd16;
    localparam logic [4:0] S_CMP_O = 5'd17;
    localparam logic [4:0] S_EQA_M = 5'd18;
    localparam logic [4:0] S_EQA_D = 5'd19;
    localparam logic [4:0] S_EQA_W = 5'd20;
    localparam logic [4:0] S_EQB_M = 5'd21;
    localparam logic [4:0] S_EQB_D = 5'd22;
    localparam logic [4:0] S_EQB_W = 5'd23;
    localparam logic [4:0] S_EQ_O  = 5'd24;
    localparam logic [4:0] S_LDB   = 5'd25;

    logic [4:0] state_reg, state_next;
    wsel_t      tgt_reg, tgt_next;
    logic       uses_b, addsub;

    assign uses_b = stat.op <= OP_LT;
    assign addsub = (stat.op == OP_ADD) || (stat.op == OP_SUB);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        tgt_next   = tgt_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DEC;
                end
            S_DEC:
                priority if (stat.op > OP_DEC)
                begin
                    cmd.out_go = 1'b1; cmd.out_st = ST_OK; state_next = S_IDLE;
                end
                else if (stat.zden)
                begin
                    cmd.out_go = 1'b1; cmd.out_st = ST_ZDEN; state_next = S_IDLE;
                end
                else if (stat.op == OP_EQ)
                    state_next = S_EQA_M;
                else if ((stat.op == OP_GT) || (stat.op == OP_LT))
                    state_next = S_CMP_P;
                else if ((stat.op == OP_DIV) && stat.bn_zero)
                begin
                    cmd.out_go = 1'b1; cmd.out_st = ST_DIV0; state_next = S_IDLE;
                end
                else
                begin
                    cmd.w_load = 1'b1; cmd.w_sel = WS_A;
                    tgt_next   = WS_A; state_next = S_NZ;
                end
            S_NZ:
                if (stat.w_zero)
                begin
                    cmd.w_one = 1'b1; state_next = S_NST;
                end
                else
                begin
                    cmd.gcd_init = 1'b1; state_next = S_GCD;
                end
            S_GCD:
                if (stat.gcd_eq)
                begin
                    cmd.div_go = 1'b1; cmd.div_dst = DD_MN; state_next = S_DWN;
                end
                else
                    cmd.gcd_step = 1'b1;
            S_DWN:
                if (stat.div_done)
                begin
                    cmd.div_go = 1'b1; cmd.div_dst = DD_MD; state_next = S_DWD;
                end
            S_DWD:
                if (stat.div_done)
                    state_next = S_FIX;
            S_FIX:
            begin
                cmd.w_fix  = 1'b1;
                state_next = S_NST;
            end
            S_NST:
                unique case (tgt_reg)
                    WS_A:
                    begin
                        cmd.w_store = 1'b1;
                        cmd.w_sel   = WS_A;
                        state_next  = uses_b ? S_LDB : S_CHK;
                    end
                    WS_B:
                    begin
                        cmd.w_store = 1'b1; cmd.w_sel = WS_B; state_next = S_CHK;
                    end
                    default: state_next = S_ROUT;
                endcase
            // a is stored; bring b into the working pair
            S_LDB:
            begin
                cmd.w_load = 1'b1; cmd.w_sel = WS_B;
                tgt_next   = WS_B; state_next = S_NZ;
            end
            S_CHK:
                priority if (!stat.a_fits || (uses_b && !stat.b_fits))
                begin
                    cmd.out_go = 1'b1; cmd.out_st = ST_OVF; state_next = S_IDLE;
                end
                else if ((stat.op == OP_INC) || (stat.op == OP_DEC))
                    state_next = S_FORM;
                else
                    state_next = S_M1;
            S_M1:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_dst = MD_P;
                cmd.mul_sel = (stat.op == OP_MUL) ? MS_AN_BN : MS_AN_BD;
                state_next  = addsub ? S_M2 : S_M3;
            end
            S_M2:
            begin
                cmd.mul_go = 1'b1; cmd.mul_dst = MD_Q; cmd.mul_sel = MS_BN_AD;
                state_next = S_M3;
            end
            S_M3:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_dst = MD_R;
                cmd.mul_sel = (stat.op == OP_DIV) ? MS_AD_BN : MS_AD_BD;
                state_next  = S_FORM;
            end
            S_FORM:
                if (addsub && !stat.pqr_ok)
                begin
                    cmd.out_go = 1'b1; cmd.out_st = ST_OVF; state_next = S_IDLE;
                end
                else
                begin
                    cmd.form = 1'b1; state_next = S_RCHK;
                end
            S_RCHK:
                if (!stat.res_fits)
                begin
                    cmd.out_go = 1'b1; cmd.out_st = ST_OVF; state_next = S_IDLE;
                end
                else
                begin
                    cmd.w_load = 1'b1; cmd.w_sel = WS_R;
                    tgt_next   = WS_R; state_next = S_NZ;
                end
            S_ROUT:
            begin
                cmd.out_go = 1'b1;
                cmd.out_w  = stat.out_fits;
                cmd.out_st = stat.out_fits ? ST_OK : ST_OVF;
                state_next = S_IDLE;
            end
            S_CMP_P:
            begin
                cmd.mul_go = 1'b1; cmd.mul_dst = MD_P; cmd.mul_sel = MS_AN_BD;
                state_next = S_CMP_Q;
            end
            S_CMP_Q:
            begin
                cmd.mul_go = 1'b1; cmd.mul_dst = MD_Q; cmd.mul_sel = MS_BN_AD;
                state_next = S_CMP_O;
            end
            S_CMP_O:
            begin
                cmd.out_go = 1'b1; cmd.out_st = ST_OK; cmd.cmp_sel = CS_ORD;
                state_next = S_IDLE;
            end
            S_EQA_M:
            begin
                cmd.mul_go = 1'b1; cmd.mul_dst = MD_P; cmd.mul_sel = MS_AN_SC;
                state_next = S_EQA_D;
            end
            S_EQA_D:
            begin
                cmd.div_go = 1'b1; cmd.div_dst = DD_QA; state_next = S_EQA_W;
            end
            S_EQA_W:
                if (stat.div_done)
                    state_next = S_EQB_M;
            S_EQB_M:
            begin
                cmd.mul_go = 1'b1; cmd.mul_dst = MD_P; cmd.mul_sel = MS_BN_SC;
                state_next = S_EQB_D;
            end
            S_EQB_D:
            begin
                cmd.div_go = 1'b1; cmd.div_dst = DD_QB; state_next = S_EQB_W;
            end
            S_EQB_W:
                if (stat.div_done)
                    state_next = S_EQ_O;
            S_EQ_O:
            begin
                cmd.out_go = 1'b1; cmd.out_st = ST_OK; cmd.cmp_sel = CS_EQ;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tgt_reg   <= WS_A;
        end
        else
        begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

### test/rational_arithmetic_unit_top_tb.sv
// Self-checking testbench of the rational arithmetic unit: random and directed commands.
`timescale 1ns / 1ps

module rational_arithmetic_unit_top_tb;
    import rau_pkg::*;

    // One command; frac_res_t below holds the result it should produce.
    typedef struct {
        op_t                op;
        logic signed [31:0] an;
        logic signed [31:0] ad;
        logic signed [31:0] bn;
        logic signed [31:0] bd;
    } cmd_item_t;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               cmp;
        st_t                st;
    } frac_res_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 1000;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
    logic               done;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               cmp_true;
    logic [1:0]         status;

    cmd_item_t pending_cmds[$];
    frac_res_t expected_results[$];

    int  send_idle_pct;     // chance in a hundred that the driver holds off a cycle
    int  errors;
    int  n_sent;
    int  n_checked;
    int  quiet_cycles;
    int  op_hits[16];
    int  st_hits[4];

    rational_arithmetic_unit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .done     (done),
        .res_num  (res_num),
        .res_den  (res_den),
        .cmp_true (cmp_true),
        .status   (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor helpers, all in 64-bit arithmetic (signed and unsigned).
    // ------------------------------------------------------------------
    function automatic logic fits32(longint x);
        return (x >= MIN32) && (x <= MAX32);
    endfunction

    function automatic longint unsigned magnitude(longint x);
        return (x < 0) ? (64'd0 - longint'(x)) : longint'(x);
    endfunction

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Lowest terms with the sign on the numerator; 0/x becomes 0/1.
    function automatic void reduce_frac(inout longint n, inout longint d);
        longint unsigned g;
        if (n == 0)
        begin
            d = 1;
            return;
        end
        g = gcd64(magnitude(n), magnitude(d));
        n = n / longint'(g);
        d = d / longint'(g);
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
    endfunction

    function automatic frac_res_t predict_result(cmd_item_t c);
        frac_res_t r;
        longint an, ad, bn, bd, rn, rd, p, q;
        logic uses_b, ok;
        an = c.an;
        ad = c.ad;
        bn = c.bn;
        bd = c.bd;
        rn = 0;
        rd = 1;
        r.cmp = 1'b0;
        r.st = ST_OK;
        uses_b = (c.op <= OP_LT);
        if (c.op > OP_DEC)
        begin
            // unused codes give 0/1 with ok status
        end
        else if (ad == 0 || (uses_b && bd == 0))
            r.st = ST_ZDEN;
        else if (c.op == OP_EQ)
            r.cmp = ((an * 1000) / ad) == ((bn * 1000) / bd);
        else if (c.op == OP_GT || c.op == OP_LT)
        begin
            p = an * bd;
            q = bn * ad;
            if ((ad < 0) != (bd < 0))
            begin
                p = -p;
                q = -q;
            end
            r.cmp = (c.op == OP_GT) ? (p > q) : (p < q);
        end
        else if (c.op == OP_DIV && bn == 0)
            r.st = ST_DIV0;
        else
        begin
            reduce_frac(an, ad);
            reduce_frac(bn, bd);
            if (!fits32(an) || !fits32(ad) || (uses_b && (!fits32(bn) || !fits32(bd))))
                r.st = ST_OVF;
            else
            begin
                ok = 1'b1;
                case (c.op)
                    OP_ADD, OP_SUB:
                    begin
                        p = an * bd;
                        q = bn * ad;
                        rd = ad * bd;
                        ok = fits32(p) && fits32(q) && fits32(rd);
                        rn = (c.op == OP_ADD) ? p + q : p - q;
                    end
                    OP_MUL:
                    begin
                        rn = an * bn;
                        rd = ad * bd;
                    end
                    OP_DIV:
                    begin
                        rn = an * bd;
                        rd = ad * bn;
                    end
                    OP_INC:
                    begin
                        rn = an + ad;
                        rd = ad;
                    end
                    default:
                    begin
                        rn = an - ad;
                        rd = ad;
                    end
                endcase
                if (!ok || !fits32(rn) || !fits32(rd))
                    r.st = ST_OVF;
                else
                begin
                    reduce_frac(rn, rd);
                    if (!fits32(rn) || rd > MAX32)
                        r.st = ST_OVF;
                end
            end
            if (r.st != ST_OK)
            begin
                rn = 0;
                rd = 1;
            end
        end
        r.num = rn[31:0];
        r.den = rd[30:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3, 4: return $signed($urandom);
            5: return $signed($urandom_range(0, 65535)) - 32'sd32768;
            default: return $signed($urandom_range(0, 40)) - 32'sd20;
        endcase
    endfunction

    // Denominators: mostly nonzero, zero now and then to hit the input check.
    function automatic logic signed [31:0] rand_den();
        logic signed [31:0] d;
        if ($urandom_range(0, 49) == 0)
            return 32'sd0;
        d = rand_word();
        return (d == 0) ? 32'sd1 : d;
    endfunction

    task automatic add_cmd(op_t o, int an, int ad, int bn, int bd);
        cmd_item_t c;
        c.op = o;
        c.an = an;
        c.ad = ad;
        c.bn = bn;
        c.bd = bd;
        pending_cmds.push_back(c);
    endtask

    task automatic add_random_cmds(int count);
        cmd_item_t c;
        repeat (count)
        begin
            // unused op codes stay rare; all four op bits still toggle
            c.op = ($urandom_range(0, 29) == 0) ? op_t'($urandom_range(9, 15))
                                                : op_t'($urandom_range(0, 8));
            c.an = rand_word();
            c.ad = rand_den();
            c.bn = rand_word();
            c.bd = rand_den();
            pending_cmds.push_back(c);
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: one command at a time from the pending queue. The command on
    // the ports is always the head of the queue; it is removed on transfer.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op    <= '0;
            a_num <= '0;
            a_den <= '0;
            b_num <= '0;
            b_den <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                // transfer this edge; predict it now
                expected_results.push_back(predict_result(pending_cmds.pop_front()));
                op_hits[op]++;
                n_sent++;
            end
            if ((!start || !busy) && pending_cmds.size() > 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cmd_item_t c;
                c = pending_cmds[0];
                start <= 1'b1;
                op    <= c.op;
                a_num <= c.an;
                a_den <= c.ad;
                b_num <= c.bn;
                b_den <= c.bd;
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each strobed result with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                frac_res_t e;
                quiet_cycles <= 0;
                if (expected_results.size() == 0)
                begin
                    $error("result with no command outstanding: %0d/%0d",
                           res_num, res_den);
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    n_checked++;
                    st_hits[e.st]++;
                    if (res_num !== e.num)
                    begin
                        $error("res_num: expected %0d, got %0d", e.num, res_num);
                        errors++;
                    end
                    if (res_den !== e.den)
                    begin
                        $error("res_den: expected %0d, got %0d", e.den, res_den);
                        errors++;
                    end
                    if (cmp_true !== e.cmp)
                    begin
                        $error("cmp_true: expected %0b, got %0b", e.cmp, cmp_true);
                        errors++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, got %0d", e.st, status);
                        errors++;
                    end
                end
            end
            else if (start && !busy)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: fails the test once quiet_cycles reaches WATCHDOG_LIMIT.
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed corner cases, then three random phases.
    // ------------------------------------------------------------------
    initial
    begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        quiet_cycles = 0;
        send_idle_pct = 20;
        foreach (op_hits[i]) op_hits[i] = 0;
        foreach (st_hits[i]) st_hits[i] = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // every op on plain fractions
        add_cmd(OP_ADD, 1, 2, 1, 3);
        add_cmd(OP_SUB, 1, 2, 1, 2);           // zero numerator -> 0/1
        add_cmd(OP_MUL, -6, 4, 2, -3);          // sign moves to numerator
        add_cmd(OP_DIV, 3, 7, -9, 14);
        add_cmd(OP_EQ, 1, 3, 333, 999);
        add_cmd(OP_EQ, 1, 3, 1, 2);
        add_cmd(OP_GT, -1, -2, 1, 3);
        add_cmd(OP_LT, 1, -3, 1, 3);
        add_cmd(OP_INC, 5, -7, 0, 0);           // b ignored, zero b_den allowed
        add_cmd(OP_DEC, -5, 7, 1, 1);
        // zero input denominator on a and on b
        add_cmd(OP_ADD, 1, 0, 1, 1);
        add_cmd(OP_GT, 1, 1, 1, 0);
        // divide by zero
        add_cmd(OP_DIV, 1, 2, 0, 5);
        // overflow: extreme values and products
        add_cmd(OP_MUL, 32'h7fffffff, 1, 2, 1);
        add_cmd(OP_ADD, 32'h7fffffff, 1, 1, 1);
        add_cmd(OP_MUL, 32'h80000000, -1, 1, 1); // reduced input out of range
        add_cmd(OP_DEC, 32'h80000000, 1, 0, 1);
        add_cmd(OP_ADD, 65537, 65536, 1, 65535);
        add_cmd(OP_DIV, 1, 32'h80000000, -1, 1);
        add_cmd(OP_EQ, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        add_cmd(OP_LT, 32'h80000000, 1, 32'h7fffffff, -1);
        add_cmd(OP_INC, 32'h7fffffff, 1, 0, 1);
        add_cmd(4'd9, 1, 0, 1, 0);              // unused code
        add_cmd(4'd15, -1, -1, -1, -1);
        wait_drained();

        send_idle_pct = 20;
        add_random_cmds(250);
        wait_drained();
        send_idle_pct = 80;
        add_random_cmds(250);
        wait_drained();
        send_idle_pct = 0;
        add_random_cmds(250);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands sent, %0d results checked; ops add..dec %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 n_sent, n_checked, op_hits[0], op_hits[1], op_hits[2], op_hits[3],
                 op_hits[4], op_hits[5], op_hits[6], op_hits[7], op_hits[8]);
        $display("statuses ok/ovf/div0/zden: %0d %0d %0d %0d",
                 st_hits[0], st_hits[1], st_hits[2], st_hits[3]);
        if (errors == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
